FILE: src/awfl_pkg.sv
// ----------------------------------------------------------------------------
// awfl_pkg
// Shared types and operation codes for the eight-bit ALU with flag logic.
// ----------------------------------------------------------------------------
package awfl_pkg;

  // operation codes; codes 17 to 31 are a no-op
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_CPL   = 5'd10,
    OP_SCF   = 5'd11,
    OP_CCF   = 5'd12,
    OP_RLA   = 5'd13,
    OP_RL    = 5'd14,
    OP_BIT   = 5'd15,
    OP_ADD16 = 5'd16
  } op_e;

  // flag bit positions in the packed flag nibble
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef struct packed {
    logic [4:0]  operation;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } out_t;

endpackage

FILE: src/awfl_calc.sv
// ----------------------------------------------------------------------------
// awfl_calc
// Combinational ALU datapath: result value and new Z/N/H/C flags.
// ----------------------------------------------------------------------------
module awfl_calc (
  input  awfl_pkg::in_t  op_i,
  output awfl_pkg::out_t res_o
);

  logic [7:0]  a, b;
  logic        cy, zin;
  logic        t_add, t_sub;
  logic [8:0]  sum9, diff9;
  logic [4:0]  hsum, hdiff;
  logic [7:0]  inc8, dec8, rl8;
  logic [16:0] sum17;
  logic [12:0] hsum16;
  logic [15:0] r;
  logic        fz, fn, fh, fc;

  assign a   = op_i.operand_a[7:0];
  assign b   = op_i.operand_b[7:0];
  assign cy  = op_i.flags_in[awfl_pkg::FlagC];
  assign zin = op_i.flags_in[awfl_pkg::FlagZ];

  assign t_add = (op_i.operation == awfl_pkg::OP_ADC) ? cy : 1'b0;
  assign t_sub = (op_i.operation == awfl_pkg::OP_SBC) ? cy : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, t_add};
  assign hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t_add};
  // borrow shows up as the sign bit of the widened difference
  assign diff9 = {1'b0, a} - {1'b0, b} - {8'd0, t_sub};
  assign hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t_sub};

  assign inc8 = a + 8'd1;
  assign dec8 = a - 8'd1;
  assign rl8  = {a[6:0], cy};

  assign sum17  = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign hsum16 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};

  always_comb begin
    r  = {8'd0, a};
    fz = zin;
    fn = op_i.flags_in[awfl_pkg::FlagN];
    fh = op_i.flags_in[awfl_pkg::FlagH];
    fc = cy;
    case (op_i.operation)
      awfl_pkg::OP_ADD, awfl_pkg::OP_ADC: begin
        r  = {8'd0, sum9[7:0]};
        fz = (sum9[7:0] == 8'd0);
        fn = 1'b0;
        fh = hsum[4];
        fc = sum9[8];
      end
      awfl_pkg::OP_SUB, awfl_pkg::OP_SBC, awfl_pkg::OP_CP: begin
        if (op_i.operation != awfl_pkg::OP_CP) begin
          r = {8'd0, diff9[7:0]};
        end
        fz = (diff9[7:0] == 8'd0);
        fn = 1'b1;
        fh = hdiff[4];
        fc = diff9[8];
      end
      awfl_pkg::OP_AND: begin
        r  = {8'd0, a & b};
        fz = ((a & b) == 8'd0);
        fn = 1'b0;
        fh = 1'b1;
        fc = 1'b0;
      end
      awfl_pkg::OP_XOR: begin
        r  = {8'd0, a ^ b};
        fz = ((a ^ b) == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      awfl_pkg::OP_OR: begin
        r  = {8'd0, a | b};
        fz = ((a | b) == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      awfl_pkg::OP_INC: begin
        r  = {8'd0, inc8};
        fz = (inc8 == 8'd0);
        fn = 1'b0;
        fh = (a[3:0] == 4'hf);
      end
      awfl_pkg::OP_DEC: begin
        r  = {8'd0, dec8};
        fz = (dec8 == 8'd0);
        fn = 1'b1;
        fh = (a[3:0] == 4'h0);
      end
      awfl_pkg::OP_CPL: begin
        r  = {8'd0, ~a};
        fn = 1'b1;
        fh = 1'b1;
      end
      awfl_pkg::OP_SCF: begin
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b1;
      end
      awfl_pkg::OP_CCF: begin
        fn = 1'b0;
        fh = 1'b0;
        fc = ~cy;
      end
      awfl_pkg::OP_RLA, awfl_pkg::OP_RL: begin
        r  = {8'd0, rl8};
        // rla always clears zero
        fz = (op_i.operation == awfl_pkg::OP_RL) && (rl8 == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[7];
      end
      awfl_pkg::OP_BIT: begin
        fz = ~a[op_i.bit_index];
        fn = 1'b0;
        fh = 1'b1;
      end
      awfl_pkg::OP_ADD16: begin
        r  = sum17[15:0];
        fn = 1'b0;
        fh = hsum16[12];
        fc = sum17[16];
      end
      default: begin
        r = op_i.operand_a;
      end
    endcase
  end

  assign res_o.result    = r;
  assign res_o.flags_out = {fz, fn, fh, fc};

endmodule

FILE: src/alu_with_flag_logic.sv
// ----------------------------------------------------------------------------
// alu_with_flag_logic
// Eight-bit ALU with Z/N/H/C flags and a 16-bit add, in a two-register pipe.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one in_t transaction
//     (operation, operands, bit index, incoming flags)
//   output channel: out_valid_o / out_stall_i carry one out_t transaction
//     (result and new flags), exactly one per input transaction, in order
//   a transaction moves when valid is high and stall is low at a clock edge
//   path: an accepted input is held in the input register, then its result is loaded
//     into the result register, from which it can be taken when not stalled
//   throughput: one transaction per cycle while the receiver does not stall, with the
//     input register feeding the combinational ALU datapath into the result register
//   the input register keeps accepting while a finished result waits, as long
//     as it is itself empty; in_stall_o rises only when both registers
//     are full and the receiver stalls
//   a stalled result holds its value and valid stays high until taken
//   reset (rst_ni low, asynchronous) empties both registers; no other state
// ----------------------------------------------------------------------------
module alu_with_flag_logic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  awfl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output awfl_pkg::out_t out_data_o
);

  // input register stage
  logic           in_vld_q;
  awfl_pkg::in_t  in_q;
  // result register stage
  logic           out_vld_q;
  awfl_pkg::out_t out_q;
  awfl_pkg::out_t res_d;

  logic out_ready;
  logic in_ready;
  logic in_take;
  logic mid_move;

  // result register can load when empty or when its content leaves now
  assign out_ready = ~out_vld_q | ~out_stall_i;
  // input register can load when empty or when its item moves on
  assign in_ready  = ~in_vld_q | out_ready;
  assign in_take   = in_valid_i & in_ready;
  assign mid_move  = in_vld_q & out_ready;

  awfl_calc u_calc (
    .op_i  (in_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload only loads on a real transaction
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_move) begin
      out_q <= res_d;
    end
  end

  assign in_stall_o  = ~in_ready;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/awfl_checker.sv
// ----------------------------------------------------------------------------
// awfl_checker
// Port-level checks on the ALU pipe: flow, back-pressure and reset behavior.
// ----------------------------------------------------------------------------
module awfl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input awfl_pkg::out_t out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  // input back-pressure only when a result is held by the receiver
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // accepted transaction reaches the output when the receiver is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted transaction did not reach the output");

  // result valid is low right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind alu_with_flag_logic awfl_checker u_awfl_checker (.*);
